>>> sv/vbm_pkg.sv
// Shared types, constants and helpers of the volume border mask unit.
// No dependencies.
package vbm_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int MAX_SIDE   = 4096;
  localparam int CNT_BITS   = $clog2(MAX_SIDE);
  localparam int SIDE_BITS  = CNT_BITS + 1;
  localparam int IDX_BITS   = 4;
  localparam int DATA_BITS  = (PIXEL_BITS > SIDE_BITS) ? PIXEL_BITS : SIDE_BITS;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [SIDE_BITS-1:0]  side_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_SIZE_X         = 4'd0,
    REG_SIZE_Y         = 4'd1,
    REG_SIZE_Z         = 4'd2,
    REG_MODE_SELECT    = 4'd3,
    REG_BORDER_VALUE   = 4'd4,
    REG_INTERIOR_VALUE = 4'd5,
    REG_VOLUME_MINIMUM = 4'd6,
    REG_VOLUME_MAXIMUM = 4'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_FIXED = 2'd0,
    MODE_INPUT = 2'd1,
    MODE_MIN   = 2'd2,
    MODE_MAX   = 2'd3
  } mode_t;

  typedef struct packed {
    logic border;
    logic last;
  } pos_t;

  typedef struct packed {
    pix_t value;
    logic border;
    logic last;
  } res_t;

  function automatic pix_t pick(logic [1:0] mode, pix_t fixed, pix_t pix,
                                pix_t vmin, pix_t vmax);
    pix_t r;
    case (mode)
      MODE_FIXED: r = fixed;
      MODE_INPUT: r = pix;
      MODE_MIN:   r = vmin;
      MODE_MAX:   r = vmax;
      default:    r = fixed;
    endcase
    return r;
  endfunction

endpackage

>>> sv/volume_border_mask_unit.sv
// Top level of the volume border mask unit: configuration registers,
// value selection and output register with skid stage.
// Depends on vbm_pkg and vbm_position.
//
// Usage: voxels enter on in_valid / in_stall in raster order (x fastest,
// then y, then z). Each accepted request yields exactly one result on
// out_valid / out_stall: the replacement value, the border flag and a flag
// on the final voxel of the volume.
// A voxel accepted while the output register is empty or being taken is
// registered straight into it. Throughput is one voxel per cycle while the
// receiver does not stall; the position flags and the select mux settle within the cycle.
// When the receiver stalls, the output holds and one more request lands in
// the skid stage; in_stall then rises until the output is taken.
// Configuration goes through cfg_valid / cfg_ready (always ready) with a
// register index and data; write it only while the block is idle. Indexes
// beyond the register list are ignored.
// Reset (rst_n low, synchronous) empties the output, clears the position
// counters and loads the register defaults: a 3x3x1 volume, fixed values
// 1 on the border and 0 inside, minimum 0, maximum 65535.
module volume_border_mask_unit import vbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pix_t                 in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pix_t                 out_value_out,
  output logic                 out_is_border,
  output logic                 out_last_of_volume,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [DATA_BITS-1:0] cfg_data
);

  side_t      size_x_r, size_y_r, size_z_r;
  logic [3:0] mode_r;
  pix_t       border_val_r, interior_val_r, vmin_r, vmax_r;

  logic out_valid_r, out_valid_nxt;
  logic skid_full_r, skid_full_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  res_t res;
  pos_t pos;
  logic accept, take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full_r;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r       <= side_t'(3);
      size_y_r       <= side_t'(3);
      size_z_r       <= side_t'(1);
      mode_r         <= 4'd0;
      border_val_r   <= pix_t'(1);
      interior_val_r <= '0;
      vmin_r         <= '0;
      vmax_r         <= pix_t'(65535);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_X:         size_x_r       <= cfg_data[SIDE_BITS-1:0];
        REG_SIZE_Y:         size_y_r       <= cfg_data[SIDE_BITS-1:0];
        REG_SIZE_Z:         size_z_r       <= cfg_data[SIDE_BITS-1:0];
        REG_MODE_SELECT:    mode_r         <= cfg_data[3:0];
        REG_BORDER_VALUE:   border_val_r   <= cfg_data[PIXEL_BITS-1:0];
        REG_INTERIOR_VALUE: interior_val_r <= cfg_data[PIXEL_BITS-1:0];
        REG_VOLUME_MINIMUM: vmin_r         <= cfg_data[PIXEL_BITS-1:0];
        REG_VOLUME_MAXIMUM: vmax_r         <= cfg_data[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  vbm_position u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(accept),
    .size_x (size_x_r),
    .size_y (size_y_r),
    .size_z (size_z_r),
    .pos    (pos)
  );

  always_comb begin
    res.border = pos.border;
    res.last   = pos.last;
    res.value  = pos.border
      ? pick(mode_r[1:0], border_val_r, in_pixel_in, vmin_r, vmax_r)
      : pick(mode_r[3:2], interior_val_r, in_pixel_in, vmin_r, vmax_r);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_nxt       = out_r;
    skid_nxt      = skid_r;
    if (!out_valid_r || take) begin
      if (skid_full_r) begin
        out_nxt       = skid_r;
        out_valid_nxt = 1'b1;
        skid_full_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt      = res;
      skid_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_value_out      = out_r.value;
  assign out_is_border      = out_r.border;
  assign out_last_of_volume = out_r.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid stage full while output empty");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no output");

  a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> out_r.border)
    else $error("last voxel of volume not flagged as border");

endmodule

>>> sv/vbm_position.sv
// Raster position counters and border / last-of-volume flags.
// Depends on vbm_pkg.
module vbm_position import vbm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  side_t size_x,
  input  side_t size_y,
  input  side_t size_z,
  output pos_t  pos
);

  cnt_t col_r, col_nxt;
  cnt_t row_r, row_nxt;
  cnt_t slc_r, slc_nxt;
  cnt_t lx, ly, lz;
  logic x_last, y_last, z_last, z_en;

  function automatic cnt_t last_pos(side_t s);
    side_t m;
    if (s == '0) m = '0;
    else if (s > side_t'(MAX_SIDE)) m = side_t'(MAX_SIDE - 1);
    else m = s - side_t'(1);
    return m[CNT_BITS-1:0];
  endfunction

  always_comb begin
    lx = last_pos(size_x);
    ly = last_pos(size_y);
    lz = last_pos(size_z);
    x_last = col_r >= lx;
    y_last = row_r >= ly;
    z_last = slc_r >= lz;
    z_en   = size_z >= side_t'(3);
    pos.border = (col_r == '0) || x_last || (row_r == '0) || y_last ||
                 (z_en && ((slc_r == '0) || z_last));
    pos.last   = x_last && y_last && z_last;
    col_nxt = col_r;
    row_nxt = row_r;
    slc_nxt = slc_r;
    if (!x_last) begin
      col_nxt = col_r + cnt_t'(1);
    end else begin
      col_nxt = '0;
      if (!y_last) begin
        row_nxt = row_r + cnt_t'(1);
      end else begin
        row_nxt = '0;
        slc_nxt = z_last ? '0 : slc_r + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      slc_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      slc_r <= slc_nxt;
    end
  end

endmodule
